// ===== src/msts_pkg.sv =====
// shared constants, types and codes of the millisecond timer slot table
package msts_pkg;

   localparam int SLOTS       = 16;
   localparam int ID_WIDTH    = 8;
   localparam int COUNT_WIDTH = 32;

   // fixed widths of the result fields
   localparam int SLOT_IDX_W  = 4;
   localparam int ELAPSED_W   = 32;

   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W      = $clog2(SLOTS + 1);
   localparam int ENTRY_W     = ID_WIDTH + COUNT_WIDTH;
   localparam int RSP_FIELD_W = 1 + SLOT_IDX_W + ELAPSED_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef logic [SLOT_W-1:0]      slot_type;
   typedef logic [SCAN_W-1:0]      scan_type;
   typedef logic [ID_WIDTH-1:0]    id_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [ENTRY_W-1:0]     entry_type;
   typedef logic [SLOT_IDX_W-1:0]  slot_idx_type;
   typedef logic [ELAPSED_W-1:0]   elapsed_type;
   typedef logic [RSP_DATA_W-1:0]  rsp_data_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one result item between the controller and the output register
   typedef struct packed {
      logic         success;
      slot_idx_type slot_index;
      elapsed_type  elapsed;
      logic         running;
   } rsp_type;

endpackage

// ===== src/msts_ram.sv =====
// generic simple dual port ram, one write and one registered read port
module msts_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/msts_ctrl.sv =====
// slot walker: owner search, free slot search, tick update and valid bits
module msts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  msts_pkg::cmd_type   req_cmd,
   input  msts_pkg::id_type    req_id,
   output logic                res_valid,
   input  logic                res_ready,
   output msts_pkg::rsp_type   res,
   output logic                ram_wr_en,
   output msts_pkg::slot_type  ram_wr_addr,
   output msts_pkg::entry_type ram_wr_data,
   output msts_pkg::slot_type  ram_rd_addr,
   input  msts_pkg::entry_type ram_rd_data
);

   msts_pkg::state_type state_ff, state_in;
   msts_pkg::cmd_type   cmd_ff, cmd_in;
   msts_pkg::id_type    id_ff, id_in;
   msts_pkg::scan_type  issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   msts_pkg::slot_type  rd_slot_ff, rd_slot_in;
   logic                found_ff, found_in;
   msts_pkg::slot_type  found_slot_ff, found_slot_in;
   msts_pkg::count_type found_cnt_ff, found_cnt_in;
   logic                free_ff, free_in;
   msts_pkg::slot_type  free_slot_ff, free_slot_in;
   logic [msts_pkg::SLOTS-1:0] used_ff, used_in;

   msts_pkg::id_type    rd_owner;
   msts_pkg::count_type rd_count;
   logic                accept;
   logic                issuing;
   logic                scan_last;
   logic                owner_hit;
   logic                free_hit;
   logic                tick_wr;
   logic                claim;
   logic                retire;

   assign rd_owner  = ram_rd_data[msts_pkg::COUNT_WIDTH +: msts_pkg::ID_WIDTH];
   assign rd_count  = ram_rd_data[msts_pkg::COUNT_WIDTH-1:0];
   assign accept    = req_valid && req_ready;
   assign issuing   = (state_ff == msts_pkg::ST_SCAN) &&
                      (issue_ff < msts_pkg::scan_type'(msts_pkg::SLOTS));
   assign scan_last = (state_ff == msts_pkg::ST_SCAN) && !issuing && rd_vld_ff;

   // per-slot checks on the entry that comes back from the ram
   assign owner_hit = rd_vld_ff && used_ff[rd_slot_ff] && (rd_owner == id_ff) &&
                      (cmd_ff != msts_pkg::CMD_TICK) && !found_ff;
   assign free_hit  = rd_vld_ff && !used_ff[rd_slot_ff] && !free_ff;
   assign tick_wr   = rd_vld_ff && used_ff[rd_slot_ff] && (cmd_ff == msts_pkg::CMD_TICK);
   assign claim     = (cmd_ff == msts_pkg::CMD_START) && !found_ff && free_ff;
   assign retire    = (state_ff == msts_pkg::ST_DONE) && res_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msts_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = msts_pkg::ST_SCAN;
            end
         end
         msts_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = msts_pkg::ST_DONE;
            end
         end
         msts_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = msts_pkg::ST_IDLE;
            end
         end
         default: state_in = msts_pkg::ST_IDLE;
      endcase
   end

   // scan bookkeeping and valid bit update
   always_comb begin
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      issue_in      = issue_ff;
      rd_vld_in     = issuing;
      rd_slot_in    = issue_ff[msts_pkg::SLOT_W-1:0];
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      found_cnt_in  = found_cnt_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      used_in       = used_ff;
      if (accept) begin
         cmd_in   = req_cmd;
         id_in    = req_id;
         issue_in = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
      end
      if (issuing) begin
         issue_in = issue_ff + 1'b1;
      end
      if (owner_hit) begin
         found_in      = 1'b1;
         found_slot_in = rd_slot_ff;
         found_cnt_in  = rd_count;
      end
      if (free_hit) begin
         free_in      = 1'b1;
         free_slot_in = rd_slot_ff;
      end
      if (retire && claim) begin
         used_in[free_slot_ff] = 1'b1;
      end
      if (retire && (cmd_ff == msts_pkg::CMD_STOP) && found_ff) begin
         used_in[found_slot_ff] = 1'b0;
      end
   end

   // outputs: handshake, ram port and result item
   always_comb begin
      req_ready   = (state_ff == msts_pkg::ST_IDLE);
      res_valid   = (state_ff == msts_pkg::ST_DONE);
      ram_rd_addr = issue_ff[msts_pkg::SLOT_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_slot_ff;
      ram_wr_data = {rd_owner, msts_pkg::count_type'(rd_count + 1'b1)};
      if (tick_wr) begin
         ram_wr_en = 1'b1;
      end
      if (retire && claim) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = free_slot_ff;
         ram_wr_data = {id_ff, msts_pkg::count_type'(0)};
      end
      res.success    = found_ff;
      res.slot_index = '0;
      res.elapsed    = '0;
      res.running    = |used_in;
      case (cmd_ff)
         msts_pkg::CMD_TICK: begin
            res.success = 1'b1;
         end
         msts_pkg::CMD_START: begin
            res.success = found_ff || free_ff;
            if (found_ff) begin
               res.slot_index = msts_pkg::slot_idx_type'(found_slot_ff);
               res.elapsed    = msts_pkg::elapsed_type'(found_cnt_ff);
            end else if (free_ff) begin
               res.slot_index = msts_pkg::slot_idx_type'(free_slot_ff);
            end
         end
         msts_pkg::CMD_READ: begin
            if (found_ff) begin
               res.slot_index = msts_pkg::slot_idx_type'(found_slot_ff);
               res.elapsed    = msts_pkg::elapsed_type'(found_cnt_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= msts_pkg::ST_IDLE;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         free_ff   <= 1'b0;
         used_ff   <= '0;
         issue_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         found_ff  <= found_in;
         free_ff   <= free_in;
         used_ff   <= used_in;
         issue_ff  <= issue_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      rd_slot_ff    <= rd_slot_in;
      found_slot_ff <= found_slot_in;
      found_cnt_ff  <= found_cnt_in;
      free_slot_ff  <= free_slot_in;
   end

   // a claimed slot was free when the walk saw it
   a_claim_free: assert property (@(posedge clock) disable iff (reset)
      (retire && claim) |-> !used_ff[free_slot_ff])
      else $error("claim of an occupied slot");

   // an owner match always points at an occupied slot
   a_found_used: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == msts_pkg::ST_DONE) && found_ff) |-> used_ff[found_slot_ff])
      else $error("owner match on a free slot");

   // a stop of a known timer frees its slot
   a_stop_frees: assert property (@(posedge clock) disable iff (reset)
      (retire && (cmd_ff == msts_pkg::CMD_STOP) && found_ff)
      |=> !used_ff[$past(found_slot_ff)])
      else $error("stop left the slot occupied");

   // no new item while a walk is under way
   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msts_pkg::ST_SCAN) |=> !$past(accept))
      else $error("item taken during a walk");

endmodule

// ===== src/millisecond_timer_slot_table_unit.sv =====
// top level of the millisecond timer slot table with its output register
//
// Keeps up to 16 elapsed-time counters, each owned by an 8-bit timer id, in
// one ram of owner and count per slot, with the occupied flags in flops.
// Every item (tick, start, stop, read) walks all slots through the ram's
// single read port, so a new item is taken only once the last is through:
// accept in idle, the walk with its registered ram read, then a state to
// commit the update and hand the result on. A tick adds one to each occupied
// counter during the walk; a start claims the lowest free slot when the id
// owns none. Results go through an output register, so the next item is
// accepted while a result still waits downstream.
module millisecond_timer_slot_table_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // timer_id[7:0]
   input  logic [1:0]             req_tuser,  // command[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // success[0], slot_index[4:1], elapsed[36:5], running[37], zero fill
   output msts_pkg::rsp_data_type rsp_tdata
);

   logic                res_valid;
   logic                res_ready;
   msts_pkg::rsp_type   res;
   logic                ram_wr_en;
   msts_pkg::slot_type  ram_wr_addr;
   msts_pkg::entry_type ram_wr_data;
   msts_pkg::slot_type  ram_rd_addr;
   msts_pkg::entry_type ram_rd_data;
   msts_pkg::rsp_type   rsp_ff, rsp_in;
   logic                full_ff, full_in;

   // owner and count per slot
   msts_ram #(
      .WIDTH (msts_pkg::ENTRY_W),
      .DEPTH (msts_pkg::SLOTS),
      .ADDR_W(msts_pkg::SLOT_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   msts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (msts_pkg::cmd_type'(req_tuser)),
      .req_id     (msts_pkg::id_type'(req_tdata)),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   // output register: loads when empty or drained in the same cycle
   assign res_ready = !full_ff || rsp_tready;

   always_comb begin
      rsp_in  = rsp_ff;
      full_in = full_ff;
      if (res_valid && res_ready) begin
         rsp_in  = res;
         full_in = 1'b1;
      end else if (rsp_tready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // pack the result fields, lowest field first
   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = msts_pkg::rsp_data_type'({rsp_ff.running, rsp_ff.elapsed,
                                                 rsp_ff.slot_index, rsp_ff.success});

endmodule

// ===== tb/tb_millisecond_timer_slot_table_unit.sv =====
// testbench for the millisecond timer slot table unit with its own table predictor
`timescale 1ns / 1ps

// table predictor and store of expected replies
class slot_table_tracker;
   msts_pkg::id_type    owner [msts_pkg::SLOTS];
   bit                  used [msts_pkg::SLOTS];
   msts_pkg::count_type count [msts_pkg::SLOTS];
   int                  occupied;
   msts_pkg::rsp_type   expected_replies [$];
   int                  fails;

   function new();
      foreach (used[i]) begin
         used[i] = 1'b0;
      end
      occupied = 0;
      fails    = 0;
   endfunction

   function int find_owner(msts_pkg::id_type id);
      for (int i = 0; i < msts_pkg::SLOTS; i++) begin
         if (used[i] && owner[i] == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   // apply one accepted command to the table and queue its reply
   function void note_command(msts_pkg::cmd_type cmd, msts_pkg::id_type id);
      msts_pkg::rsp_type r;
      int                hit;
      r   = '0;
      hit = -1;
      case (cmd)
         msts_pkg::CMD_TICK: begin
            for (int i = 0; i < msts_pkg::SLOTS; i++) begin
               if (used[i]) begin
                  count[i] = count[i] + 1'b1;
               end
            end
            r.success = 1'b1;
         end
         msts_pkg::CMD_START: begin
            hit = find_owner(id);
            // lowest free slot when the id holds none
            if (hit < 0) begin
               for (int i = msts_pkg::SLOTS - 1; i >= 0; i--) begin
                  if (!used[i]) begin
                     hit = i;
                  end
               end
               if (hit >= 0) begin
                  used[hit]  = 1'b1;
                  owner[hit] = id;
                  count[hit] = '0;
                  occupied++;
               end
            end
            r.success = (hit >= 0);
         end
         msts_pkg::CMD_STOP: begin
            hit = find_owner(id);
            if (hit >= 0) begin
               used[hit] = 1'b0;
               occupied--;
               r.success = 1'b1;
            end
            hit = -1;
         end
         default: begin
            hit = find_owner(id);
            r.success = (hit >= 0);
         end
      endcase
      if (hit >= 0) begin
         r.slot_index = msts_pkg::slot_idx_type'(hit);
         r.elapsed    = msts_pkg::elapsed_type'(count[hit]);
      end
      r.running = (occupied > 0);
      expected_replies.push_back(r);
   endfunction

   function int pending();
      return expected_replies.size();
   endfunction

   task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fails++;
   endtask

   // compare one accepted reply with the oldest expectation
   task check_reply(msts_pkg::rsp_data_type d);
      msts_pkg::rsp_type      want;
      logic                   got_success;
      msts_pkg::slot_idx_type got_slot;
      msts_pkg::elapsed_type  got_elapsed;
      logic                   got_running;
      {got_running, got_elapsed, got_slot, got_success} = d[msts_pkg::RSP_FIELD_W-1:0];
      if (expected_replies.size() == 0) begin
         report($sformatf("reply %h with no command waiting", d));
         return;
      end
      want = expected_replies.pop_front();
      if (got_success !== want.success) begin
         report($sformatf("success %b, want %b", got_success, want.success));
      end
      if (got_slot !== want.slot_index) begin
         report($sformatf("slot_index %0d, want %0d", got_slot, want.slot_index));
      end
      if (got_elapsed !== want.elapsed) begin
         report($sformatf("elapsed %0d, want %0d", got_elapsed, want.elapsed));
      end
      if (got_running !== want.running) begin
         report($sformatf("running %b, want %b", got_running, want.running));
      end
   endtask
endclass

module tb_millisecond_timer_slot_table_unit;

   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_ITEMS  = 250;
   localparam int POOL_SIZE    = 24;
   localparam int SETTLE_TICKS = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // timer_id[7:0]
   logic [1:0]             req_tuser;   // command[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // success[0], slot_index[4:1], elapsed[36:5], running[37]
   msts_pkg::rsp_data_type rsp_tdata;

   slot_table_tracker tracker = new();

   int               send_idle;
   int               recv_idle;
   int               quiet_cycles;
   msts_pkg::id_type id_pool [POOL_SIZE];

   millisecond_timer_slot_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls at random, changes on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // reply check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_reply(rsp_tdata);
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("millisecond_timer_slot_table_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one command, entered and left at a falling edge
   task send_item(msts_pkg::cmd_type cmd, msts_pkg::id_type id);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= id;
      do @(posedge clock); while (!req_tready);
      tracker.note_command(cmd, id);
      @(negedge clock);
   endtask

   task drain_replies();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   // well-formed traffic on a small id pool, with some stray ids
   task random_commands(int n);
      int                r;
      msts_pkg::cmd_type cmd;
      msts_pkg::id_type  id;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 30) cmd = msts_pkg::CMD_TICK;
         else if (r < 55) cmd = msts_pkg::CMD_START;
         else if (r < 75) cmd = msts_pkg::CMD_STOP;
         else cmd = msts_pkg::CMD_READ;
         if ($urandom_range(9) == 0) id = msts_pkg::id_type'($urandom);
         else id = id_pool[$urandom_range(POOL_SIZE - 1)];
         send_item(cmd, id);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = msts_pkg::CMD_TICK;
      send_idle  = 29;
      recv_idle  = 85;
      // pool holds the ids left behind by the directed part, the refused id 77 and random ids
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 14) id_pool[i] = msts_pkg::id_type'(i + 1);
         else if (i == 14) id_pool[i] = 8'hAA;
         else if (i == 15) id_pool[i] = 8'h77;
         else id_pool[i] = msts_pkg::id_type'($urandom);
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, unknown ids, id zero and all-ones, full table
      send_item(msts_pkg::CMD_TICK, 8'h3C);
      send_item(msts_pkg::CMD_READ, 8'h00);
      send_item(msts_pkg::CMD_STOP, 8'h55);
      send_item(msts_pkg::CMD_START, 8'h00);
      send_item(msts_pkg::CMD_START, 8'hFF);
      send_item(msts_pkg::CMD_START, 8'hFF);
      send_item(msts_pkg::CMD_TICK, 8'hC3);
      send_item(msts_pkg::CMD_READ, 8'hFF);
      send_item(msts_pkg::CMD_STOP, 8'h00);
      send_item(msts_pkg::CMD_START, 8'hAA);
      for (int k = 1; k <= 14; k++) begin
         send_item(msts_pkg::CMD_START, msts_pkg::id_type'(k));
      end
      send_item(msts_pkg::CMD_START, 8'h77);
      send_item(msts_pkg::CMD_STOP, 8'hFF);
      drain_replies();

      random_commands(PHASE_ITEMS);
      drain_replies();

      send_idle = 85;
      recv_idle = 29;
      random_commands(PHASE_ITEMS);
      drain_replies();

      send_idle = 0;
      recv_idle = 0;
      random_commands(PHASE_ITEMS);
      drain_replies();

      repeat (SETTLE_TICKS) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.report($sformatf("%0d replies never came", tracker.pending()));
      end
      if (tracker.fails == 0) begin
         $display("millisecond_timer_slot_table_unit test passed");
      end else begin
         $display("millisecond_timer_slot_table_unit test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/msts_pkg.sv
src/msts_ram.sv
src/msts_ctrl.sv
src/millisecond_timer_slot_table_unit.sv
tb/tb_millisecond_timer_slot_table_unit.sv
